FILE: design/uvp_pkg.sv
// Shared types and constants for the unused-vertex purge block.
`timescale 1ns / 1ps

package uvp_pkg;

	localparam int unsigned DEFAULT_MAX_POINTS = 65536;
	localparam int unsigned PC_W    = 17;
	localparam int unsigned IDX_W   = 16;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned KIND_W  = 2;

	localparam logic [PC_W-1:0]  POINT_COUNT_RESET = 17'h10000;
	localparam logic [IDX_W-1:0] DROPPED_INDEX     = 16'hFFFF;

	localparam logic [OP_W-1:0] OP_MARK    = 2'd0;
	localparam logic [OP_W-1:0] OP_POINT   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMAP   = 2'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

	localparam logic [KIND_W-1:0] KIND_POINT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMAP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

	// Control of the vertex store for one cycle.
	typedef struct packed {
		logic rd_en;
		logic used_we;
		logic used_wd;
		logic map_we;
	} mem_ctl_t;

endpackage

FILE: design/unused_vertex_purge_top.sv
// Top level of the unused-vertex purge block: sequencer, counters and output register.
`timescale 1ns / 1ps

// Compacts a mesh by dropping unreferenced vertices. The accept cycle of an
// item issues the read of the vertex store (used bit and index map share one
// address); the execute state then does the read-modify-write and loads the
// output register once that register is free, and no new item is taken until
// execute is done. After reset a clearing pass zeroes the used bits, one entry
// per cycle; in_stall stays high until it is done. point_count may be written
// at any time the block is idle (cfg_ready is always high). Index limit is
// min(point_count, MAX_POINTS).
module unused_vertex_purge_top #(
	parameter int unsigned MAX_POINTS = uvp_pkg::DEFAULT_MAX_POINTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [uvp_pkg::PC_W-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [uvp_pkg::OP_W-1:0]    operation,
	input  logic [uvp_pkg::IDX_W-1:0]   vertex_index,
	input  logic [uvp_pkg::COORD_W-1:0] coord_x,
	input  logic [uvp_pkg::COORD_W-1:0] coord_y,
	input  logic [uvp_pkg::COORD_W-1:0] coord_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [uvp_pkg::KIND_W-1:0]  kind,
	output logic [uvp_pkg::IDX_W-1:0]   new_index,
	output logic [uvp_pkg::COORD_W-1:0] out_x,
	output logic [uvp_pkg::COORD_W-1:0] out_y,
	output logic [uvp_pkg::COORD_W-1:0] out_z
);
	import uvp_pkg::*;

	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned LW = (AW + 1 > PC_W) ? AW + 1 : PC_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	logic [PC_W-1:0] point_count_q;
	logic [PC_W-1:0] point_cnt_q;
	logic [PC_W-1:0] kept_cnt_q;

	logic [OP_W-1:0]    op_s1;
	logic               range_s1;
	logic [AW-1:0]      addr_s1;
	logic [COORD_W-1:0] x_s1, y_s1, z_s1;

	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [IDX_W-1:0]    new_index_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q, out_z_q;

	mem_ctl_t         mem_ctl;
	logic             used_rdata;
	logic [IDX_W-1:0] map_rdata;
	logic [IDX_W-1:0] map_wdata;
	logic             clear_busy;

	logic [LW-1:0] lim;
	logic [LW-1:0] pc_ext;
	logic [LW-1:0] sel_idx;
	logic          accept;
	logic          in_range;
	logic          exec_go;
	logic          kept;
	logic          has_result;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;

	assign pc_ext  = LW'(point_count_q);
	assign lim     = (pc_ext > LW'(MAX_POINTS)) ? LW'(MAX_POINTS) : pc_ext;
	assign sel_idx = (operation == OP_POINT) ? LW'(point_cnt_q) : LW'(vertex_index);
	assign in_range = (sel_idx < lim);

	assign exec_go = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign kept    = (op_s1 == OP_POINT) && !range_s1 && used_rdata;
	assign has_result = range_s1 || (op_s1 == OP_REMAP) || kept;

	always_comb begin
		mem_ctl.rd_en   = accept;
		mem_ctl.used_we = exec_go && !range_s1 && ((op_s1 == OP_MARK) || kept);
		mem_ctl.used_wd = (op_s1 == OP_MARK);
		mem_ctl.map_we  = exec_go && !range_s1 && (op_s1 == OP_POINT);
		map_wdata       = used_rdata ? kept_cnt_q[IDX_W-1:0] : DROPPED_INDEX;
	end

	uvp_store #(
		.MAX_POINTS(MAX_POINTS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mem_ctl),
		.rd_addr    (sel_idx[AW-1:0]),
		.wr_addr    (addr_s1),
		.map_wdata  (map_wdata),
		.used_rdata (used_rdata),
		.map_rdata  (map_rdata),
		.clear_busy (clear_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (!clear_busy) state_q <= ST_IDLE;
				ST_IDLE:  if (accept) state_q <= ST_EXEC;
				ST_EXEC:  if (exec_go) state_q <= ST_IDLE;
				default:  state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_count_q <= POINT_COUNT_RESET;
		else if (cfg_valid && cfg_ready)
			point_count_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			range_s1 <= (operation != OP_RESTART) && !in_range;
			addr_s1  <= sel_idx[AW-1:0];
			x_s1     <= coord_x;
			y_s1     <= coord_y;
			z_s1     <= coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_cnt_q <= '0;
			kept_cnt_q  <= '0;
		end else if (exec_go) begin
			if (op_s1 == OP_RESTART) begin
				point_cnt_q <= '0;
				kept_cnt_q  <= '0;
			end else if (op_s1 == OP_POINT && !range_s1) begin
				point_cnt_q <= point_cnt_q + 1'b1;
				if (used_rdata)
					kept_cnt_q <= kept_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (exec_go && has_result)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_go && has_result) begin
			if (range_s1) begin
				kind_q      <= KIND_RANGE;
				new_index_q <= '0;
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_z_q     <= '0;
			end else if (op_s1 == OP_REMAP) begin
				kind_q      <= KIND_REMAP;
				new_index_q <= map_rdata;
				out_x_q     <= '0;
				out_y_q     <= '0;
				out_z_q     <= '0;
			end else begin
				kind_q      <= KIND_POINT;
				new_index_q <= kept_cnt_q[IDX_W-1:0];
				out_x_q     <= x_s1;
				out_y_q     <= y_s1;
				out_z_q     <= z_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign new_index = new_index_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	// Kept points never outnumber the points walked since the last restart.
	a_kept_le_points: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= point_cnt_q)
		else $error("kept counter ahead of point counter");

	// A restart zeroes both counters.
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && op_s1 == OP_RESTART) |=> (point_cnt_q == '0 && kept_cnt_q == '0))
		else $error("restart did not clear counters");

	// No result leaves while the used bits are still being cleared.
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("output valid during clearing pass");

	// A new result only comes from the execute cycle.
	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("output loaded outside execute cycle");

endmodule

FILE: design/uvp_store.sv
// Vertex store: used-bit memory with its clearing pass, and the index map memory.
`timescale 1ns / 1ps

module uvp_store #(
	parameter int unsigned MAX_POINTS = uvp_pkg::DEFAULT_MAX_POINTS,
	localparam int unsigned AW = $clog2(MAX_POINTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uvp_pkg::mem_ctl_t        ctl,
	input  logic [AW-1:0]            rd_addr,
	input  logic [AW-1:0]            wr_addr,
	input  logic [uvp_pkg::IDX_W-1:0] map_wdata,
	output logic                     used_rdata,
	output logic [uvp_pkg::IDX_W-1:0] map_rdata,
	output logic                     clear_busy
);
	import uvp_pkg::*;

	logic           used_mem [MAX_POINTS];
	logic [IDX_W-1:0] map_mem [MAX_POINTS];

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	assign clear_busy = clr_busy_q;

	// Sweep every used bit to zero after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(MAX_POINTS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			used_mem[clr_addr_q] <= 1'b0;
		else if (ctl.used_we)
			used_mem[wr_addr] <= ctl.used_wd;
		if (ctl.rd_en)
			used_rdata <= used_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.map_we)
			map_mem[wr_addr] <= map_wdata;
		if (ctl.rd_en)
			map_rdata <= map_mem[rd_addr];
	end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the unused-vertex purge block.
`timescale 1ns / 1ps

module tb_top;
	import uvp_pkg::*;

	localparam int unsigned MESH_CAP    = DEFAULT_MAX_POINTS;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned IDLE_PCT    = 17;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [IDX_W-1:0]   vidx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} vertex_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} purge_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [PC_W-1:0]    cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    operation = OP_MARK;
	logic [IDX_W-1:0]   vertex_index = '0;
	logic [COORD_W-1:0] coord_x = '0;
	logic [COORD_W-1:0] coord_y = '0;
	logic [COORD_W-1:0] coord_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [KIND_W-1:0]  kind;
	logic [IDX_W-1:0]   new_index;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic [COORD_W-1:0] out_z;

	unused_vertex_purge_top #(
		.MAX_POINTS(MESH_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.vertex_index(vertex_index),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.new_index(new_index),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z)
	);

	// Predicted block state
	bit             used_mark [MESH_CAP];
	logic [IDX_W-1:0] map_entry [MESH_CAP];
	logic [PC_W-1:0]  next_point = '0;
	logic [PC_W-1:0]  kept_total = '0;
	logic [PC_W-1:0]  point_count_q = POINT_COUNT_RESET;

	// Stimulus-side view: which map entries will have been written, so that
	// a remap never reads an entry that no point item has filled
	bit          plan_written [MESH_CAP];
	int unsigned plan_point = 0;
	int unsigned plan_limit = MESH_CAP;

	vertex_item_t  vertex_stream[$];
	purge_result_t predicted_results[$];
	vertex_item_t  offered;
	int unsigned   items_queued = 0;
	int unsigned   items_taken = 0;
	int unsigned   errors = 0;
	int unsigned   cycle_count = 0;
	int unsigned   hold_requests = 0;
	int unsigned   holds_served = 0;
	int unsigned   hold_left = 0;
	logic          calm = 1'b0;

	function automatic int unsigned limit_of(input logic [PC_W-1:0] pc);
		return (32'(pc) > MESH_CAP) ? MESH_CAP : 32'(pc);
	endfunction

	task automatic purge_predict(input vertex_item_t it);
		purge_result_t r;
		bit            hit;
		int unsigned   lim;
		int unsigned   p;
		r = '0;
		r.kind = KIND_RANGE;
		hit = 1'b0;
		lim = limit_of(point_count_q);
		p = 32'(next_point);
		case (it.op)
			OP_MARK: begin
				if (32'(it.vidx) >= lim)
					hit = 1'b1;
				else
					used_mark[it.vidx] = 1'b1;
			end
			OP_POINT: begin
				if (p >= lim) begin
					hit = 1'b1;
				end else begin
					next_point = next_point + 1'b1;
					if (used_mark[IDX_W'(p)]) begin
						used_mark[IDX_W'(p)] = 1'b0;
						map_entry[IDX_W'(p)] = kept_total[IDX_W-1:0];
						r.kind = KIND_POINT;
						r.idx = kept_total[IDX_W-1:0];
						r.x = it.x;
						r.y = it.y;
						r.z = it.z;
						kept_total = kept_total + 1'b1;
						hit = 1'b1;
					end else begin
						map_entry[IDX_W'(p)] = DROPPED_INDEX;
					end
				end
			end
			OP_REMAP: begin
				hit = 1'b1;
				if (32'(it.vidx) < lim) begin
					r.kind = KIND_REMAP;
					r.idx = map_entry[it.vidx];
				end
			end
			OP_RESTART: begin
				next_point = '0;
				kept_total = '0;
			end
		endcase
		if (hit)
			predicted_results.push_back(r);
	endtask

	task automatic queue_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] vidx,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z);
		vertex_item_t it;
		it.op = op;
		it.vidx = vidx;
		it.x = x;
		it.y = y;
		it.z = z;
		if (op == OP_RESTART) begin
			plan_point = 0;
		end else if (op == OP_POINT && plan_point < plan_limit) begin
			plan_written[IDX_W'(plan_point)] = 1'b1;
			plan_point++;
		end
		vertex_stream.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] vidx);
		queue_item(op, vidx, $urandom(), $urandom(), $urandom());
	endtask

	function automatic bit pick_remap_index(output logic [IDX_W-1:0] idx);
		int unsigned probe;
		bit          can_flag;
		can_flag = plan_limit < MESH_CAP;
		idx = '0;
		if (can_flag && (plan_point == 0 || $urandom_range(9, 0) == 0)) begin
			idx = IDX_W'($urandom_range(MESH_CAP - 1, plan_limit));
			return 1'b1;
		end
		if (plan_point > 0) begin
			idx = IDX_W'($urandom_range(plan_point - 1, 0));
			return 1'b1;
		end
		// nothing walked in this mesh yet: try entries left by earlier meshes
		for (int t = 0; t < 8; t++) begin
			probe = $urandom_range(plan_limit - 1, 0);
			if (plan_written[IDX_W'(probe)]) begin
				idx = IDX_W'(probe);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic set_point_count(input logic [PC_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		point_count_q = value;
		plan_limit = limit_of(value);
	endtask

	// Items that produce nothing may still be in flight when the last
	// result shows up, hence the extra wait at the end.
	task automatic wait_drained();
		while (items_taken != items_queued || predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				purge_predict(offered);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (vertex_stream.size() > 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
					offered = vertex_stream.pop_front();
					in_valid <= 1'b1;
					operation <= offered.op;
					vertex_index <= offered.vidx;
					coord_x <= offered.x;
					coord_y <= offered.y;
					coord_z <= offered.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_monitor
		purge_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$error("unexpected transaction: kind %0d new_index 0x%0h", kind, new_index);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					check_field("kind", COORD_W'(want.kind), COORD_W'(kind));
					check_field("new_index", COORD_W'(want.idx), COORD_W'(new_index));
					check_field("out_x", want.x, out_x);
					check_field("out_y", want.y, out_y);
					check_field("out_z", want.z, out_z);
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
			end
		end
	end

	initial begin
		logic [PC_W-1:0]  cfg;
		logic [IDX_W-1:0] idx;
		logic [OP_W-1:0]  op;
		int unsigned      roll;
		int unsigned      npts;
		int unsigned      count;
		int unsigned      mesh;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// clearing pass of the used bits
		while (in_stall !== 1'b0)
			@(posedge clk);

		// Full-size mesh: kept, dropped, remap of kept and dropped entries
		set_point_count(POINT_COUNT_RESET);
		queue_random(OP_RESTART, '0);
		queue_random(OP_MARK, 16'h0000);
		queue_random(OP_MARK, 16'hFFFF);
		queue_random(OP_MARK, 16'h0002);
		queue_item(OP_POINT, 16'hFFFF, '1, '1, '1);
		queue_item(OP_POINT, 16'h0000, '0, '0, '0);
		queue_item(OP_POINT, 16'h5A5A, 32'hA5A5A5A5, 32'h5A5A5A5A, 32'h80000001);
		queue_item(OP_REMAP, 16'h0000, '0, '0, '0);
		queue_item(OP_REMAP, 16'h0001, '0, '0, '0);
		queue_item(OP_REMAP, 16'h0002, '0, '0, '0);
		wait_drained();

		// Three vertices: indices out of range and a point past the count
		set_point_count(17'd3);
		queue_random(OP_RESTART, '0);
		queue_random(OP_MARK, 16'h0003);
		queue_random(OP_MARK, 16'h8000);
		queue_item(OP_REMAP, 16'h7FFF, '0, '0, '0);
		repeat (4) queue_random(OP_POINT, IDX_W'($urandom()));
		queue_random(OP_RESTART, '0);
		wait_drained();

		// Empty mesh flags every indexed item
		set_point_count('0);
		queue_random(OP_MARK, 16'h0000);
		queue_random(OP_POINT, 16'h0000);
		queue_item(OP_REMAP, 16'h0000, '0, '0, '0);
		wait_drained();

		set_point_count(17'd1);
		queue_random(OP_RESTART, '0);
		queue_random(OP_MARK, 16'h0000);
		queue_random(OP_POINT, 16'h0000);
		queue_item(OP_REMAP, 16'h0000, '0, '0, '0);

		mesh = 0;
		while (items_queued < 1250) begin
			wait_drained();
			roll = $urandom_range(99, 0);
			if (mesh == 0)
				cfg = 17'h1FFFF;
			else if (mesh == 2)
				cfg = PC_W'($urandom_range(200, 150));
			else if (roll < 12)
				cfg = PC_W'($urandom_range(150, 60));
			else if (roll < 22) begin
				case ($urandom_range(3, 0))
					0: cfg = '0;
					1: cfg = 17'd1;
					2: cfg = POINT_COUNT_RESET;
					default: cfg = 17'h1FFFF;
				endcase
			end else
				cfg = PC_W'($urandom_range(40, 1));
			if (mesh <= 2 || $urandom_range(3, 0) != 0)
				set_point_count(cfg);
			calm <= (mesh >= 4 && mesh < 7);
			// long output hold while this mesh streams in
			if (mesh == 2)
				hold_requests <= hold_requests + 1;

			npts = (plan_limit <= 400) ? plan_limit : $urandom_range(40, 8);
			queue_random(OP_RESTART, IDX_W'($urandom()));
			count = $urandom_range(2 * npts + 2, 0);
			for (int i = 0; i < count; i++) begin
				if (npts > 0 && $urandom_range(99, 0) < 85)
					queue_random(OP_MARK, IDX_W'($urandom_range(npts - 1, 0)));
				else
					queue_random(OP_MARK, IDX_W'($urandom()));
			end
			count = npts;
			if ($urandom_range(9, 0) == 0)
				count += $urandom_range(3, 1);
			for (int i = 0; i < count; i++)
				queue_random(OP_POINT, IDX_W'($urandom()));
			count = $urandom_range(2 * npts + 2, 1);
			for (int i = 0; i < count; i++) begin
				op = ($urandom_range(9, 0) == 0) ? OP_W'($urandom_range(3, 0)) : OP_REMAP;
				if (op != OP_REMAP)
					queue_random(op, IDX_W'($urandom()));
				else if (pick_remap_index(idx))
					queue_random(OP_REMAP, idx);
			end
			mesh++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/uvp_pkg.sv
design/uvp_store.sv
design/unused_vertex_purge_top.sv
sim/tb_top.sv
